### sv/spq_pkg.sv
// Package for the sorted priority queue: word types of both channels,
// command and status codes, and the control word broadcast to the cells.
// No dependencies.
package spq_pkg;

   // Command codes of the request word.
   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   // Status codes of the response word.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Request word.
   typedef struct packed {
      logic               cmd;
      logic signed [31:0] data_in;
      logic        [7:0]  priority_req;
   } req_word_type;

   // Response word.
   typedef struct packed {
      logic        [1:0]  status;
      logic signed [31:0] data_out;
      logic        [7:0]  count;
      logic               is_empty;
      logic               is_full;
   } rsp_word_type;

   // Operation broadcast to every cell in the chain.
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

endpackage

### sv/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and moves it
// toward either neighbor. Depends on spq_pkg.
module spq_cell #(
   parameter int DATA_BITS     = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                     clock,
   input  spq_pkg::cell_ctrl_type   ctrl,
   input  logic                     occupied,
   input  logic [DATA_BITS-1:0]     new_data,
   input  logic [PRIORITY_BITS-1:0] new_prio,
   input  logic                     left_keep,
   input  logic [DATA_BITS-1:0]     left_data,
   input  logic [PRIORITY_BITS-1:0] left_prio,
   input  logic [DATA_BITS-1:0]     right_data,
   input  logic [PRIORITY_BITS-1:0] right_prio,
   output logic                     keep,
   output logic [DATA_BITS-1:0]     data,
   output logic [PRIORITY_BITS-1:0] prio
);
   import spq_pkg::*;

   logic [DATA_BITS-1:0]     data_ff, data_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;

   // A held entry of equal or higher priority stays ahead of a new one.
   assign keep = occupied && (prio_ff >= new_prio);

   // Choose between holding, taking the new entry, or shifting.
   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      if (ctrl.enq && !keep) begin
         if (left_keep) begin
            data_in = new_data;
            prio_in = new_prio;
         end else begin
            data_in = left_data;
            prio_in = left_prio;
         end
      end else if (ctrl.deq) begin
         data_in = right_data;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign data = data_ff;
   assign prio = prio_ff;

endmodule

### sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: fill count, cell chain and
// response register. Depends on spq_pkg and spq_cell.
//
// A bounded priority queue of DEPTH entries kept as a chain of cells sorted
// by descending priority; entries of equal priority leave in arrival order.
// Each request word (enqueue or dequeue) produces exactly one response word,
// which appears in the cycle after the request is taken. One request is
// taken every clock cycle while the response side keeps up: every cell
// compares its own priority with the incoming one in the same cycle and
// either holds, loads the new entry or takes its neighbor's entry, so the
// cycle is set by one priority compare plus the broadcast of the new entry
// across the chain. The response register holds a stalled word while the
// request side stalls. An enqueue to a full queue or a dequeue from an
// empty one returns an error status and leaves the queue unchanged.
module sorted_priority_queue_core #(
   parameter int DEPTH         = 128,
   parameter int PRIORITY_BITS = 8,
   parameter int DATA_BITS     = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_word_type rsp_word
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic               accept;
   logic               full, empty;
   cell_ctrl_type      ctrl;
   logic [1:0]         status;

   logic [DATA_BITS+31:0]     din_ext;
   logic [PRIORITY_BITS+7:0]  pin_ext;
   logic [DATA_BITS-1:0]      new_data;
   logic [PRIORITY_BITS-1:0]  new_prio;
   logic [DATA_BITS+31:0]     dout_ext;
   logic [CW+7:0]             cnt_ext;

   logic [DEPTH-1:0]          occ;
   logic [DEPTH-1:0]          keep;
   logic [DATA_BITS-1:0]      cell_data [DEPTH];
   logic [PRIORITY_BITS-1:0]  cell_prio [DEPTH];

   // Take a request when the response register is free or being drained.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // Fit the incoming fields to the stored widths.
   assign din_ext  = {{DATA_BITS{1'b0}}, req_word.data_in};
   assign pin_ext  = {{PRIORITY_BITS{1'b0}}, req_word.priority_req};
   assign new_data = din_ext[DATA_BITS-1:0];
   assign new_prio = pin_ext[PRIORITY_BITS-1:0];

   // Decode the operation and its outcome.
   always_comb begin
      ctrl     = '0;
      status   = ST_OK;
      count_in = count_ff;
      if (accept) begin
         if (req_word.cmd == CMD_ENQ) begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.enq = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end else begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               ctrl.deq = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
      end
   end

   // Chain of cells; the head sits at index zero.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                     lk;
      logic [DATA_BITS-1:0]     ld, rd;
      logic [PRIORITY_BITS-1:0] lp, rp;

      assign occ[g] = (CW'(g) < count_ff);

      if (g == 0) begin : g_head
         assign lk = 1'b1;
         assign ld = new_data;
         assign lp = new_prio;
      end else begin : g_body
         assign lk = keep[g-1];
         assign ld = cell_data[g-1];
         assign lp = cell_prio[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign rd = cell_data[g];
         assign rp = cell_prio[g];
      end else begin : g_inner
         assign rd = cell_data[g+1];
         assign rp = cell_prio[g+1];
      end

      spq_cell #(
         .DATA_BITS     (DATA_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ[g]),
         .new_data   (new_data),
         .new_prio   (new_prio),
         .left_keep  (lk),
         .left_data  (ld),
         .left_prio  (lp),
         .right_data (rd),
         .right_prio (rp),
         .keep       (keep[g]),
         .data       (cell_data[g]),
         .prio       (cell_prio[g])
      );
   end

   // Build the response word from the head entry and the new count.
   assign dout_ext = {32'd0, cell_data[0]};
   assign cnt_ext  = {8'd0, count_in};

   always_comb begin
      rsp_word_in          = rsp_word_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in         = 1'b1;
         rsp_word_in.status   = status;
         rsp_word_in.data_out = ctrl.deq ? dout_ext[31:0] : 32'sd0;
         rsp_word_in.count    = cnt_ext[7:0];
         rsp_word_in.is_empty = (count_in == '0);
         rsp_word_in.is_full  = (count_in == CW'(DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### sim/sorted_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue_core: a short table of directed words,
// then random enqueue/dequeue phases checked against a sorted-list predictor.
// Depends on spq_pkg and the queue RTL.
module sorted_priority_queue_core_tb;
   import spq_pkg::*;

   localparam int DEPTH         = 128;
   localparam int RANDOM_ITEMS  = 1030;
   localparam int QUIET_ITEMS   = 150;
   localparam int DRAIN_CYCLES  = 10;
   localparam int MAX_PRINTS    = 100;

   // One row of the directed table: the request word, and a typed-in
   // response where the answer is obvious.
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // Travels alongside req_word so the monitor knows which answer to use.
   logic         drive_typed;
   rsp_word_type drive_rsp;

   // Predictor state: sorted storage, head at index zero.
   logic signed [31:0] pq_data [DEPTH];
   logic        [7:0]  pq_prio [DEPTH];
   int                 pq_fill;

   rsp_word_type pending_rsps [$];
   int           fail_count;
   int           print_count;
   bit           quiet;
   int           stall_left;

   sorted_priority_queue_core #(
      .DEPTH(DEPTH),
      .PRIORITY_BITS(8),
      .DATA_BITS(32)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Run limit, far beyond the slowest legal run.
   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic req_word_type make_req(logic cmd, logic [31:0] data, logic [7:0] prio);
      req_word_type w;
      w.cmd          = cmd;
      w.data_in      = data;
      w.priority_req = prio;
      return w;
   endfunction

   function automatic rsp_word_type make_rsp(logic [1:0] status, logic [31:0] data,
                                             logic [7:0] count, logic empty, logic full);
      rsp_word_type r;
      r.status   = status;
      r.data_out = data;
      r.count    = count;
      r.is_empty = empty;
      r.is_full  = full;
      return r;
   endfunction

   // Applies one word to the predictor state and returns the response.
   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type r;
      int           pos;
      r = '0;
      r.status = ST_OK;
      if (w.cmd == CMD_ENQ) begin
         if (pq_fill >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // Shift lower-priority entries back; ties stay ahead of the new one.
            pos = pq_fill;
            while (pos > 0 && pq_prio[pos - 1] < w.priority_req) begin
               pq_data[pos] = pq_data[pos - 1];
               pq_prio[pos] = pq_prio[pos - 1];
               pos--;
            end
            pq_data[pos] = w.data_in;
            pq_prio[pos] = w.priority_req;
            pq_fill++;
         end
      end else begin
         if (pq_fill == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.data_out = pq_data[0];
            for (int k = 1; k < pq_fill; k++) begin
               pq_data[k - 1] = pq_data[k];
               pq_prio[k - 1] = pq_prio[k];
            end
            pq_fill--;
         end
      end
      r.count    = pq_fill[7:0];
      r.is_empty = (pq_fill == 0);
      r.is_full  = (pq_fill == DEPTH);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      fail_count++;
      if (print_count < MAX_PRINTS) begin
         print_count++;
         $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
      end
   endtask

   // Priorities bunch up often so that ties and FIFO order get exercised.
   function automatic logic [7:0] pick_priority();
      case ($urandom_range(0, 9))
         5, 6, 7: return 8'($urandom_range(0, 3));
         8:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         9:       return 8'($urandom_range(250, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   // Offers one word, with an occasional gap in front, and waits for acceptance.
   task automatic send_word(req_word_type w, logic typed, rsp_word_type rsp);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_word    <= w;
      drive_typed <= typed;
      drive_rsp   <= rsp;
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver stalls come in bursts of random length.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each accepted request first, then check each accepted response.
   always @(posedge clock) begin
      rsp_word_type predicted;
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = predict_rsp(req_word);
            pending_rsps.push_back(drive_typed ? drive_rsp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_word), 32'h0);
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_word.status !== want.status)
                  report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
               if (rsp_word.data_out !== want.data_out)
                  report_mismatch("data_out", rsp_word.data_out, want.data_out);
               if (rsp_word.count !== want.count)
                  report_mismatch("count", 32'(rsp_word.count), 32'(want.count));
               if (rsp_word.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_word.is_empty), 32'(want.is_empty));
               if (rsp_word.is_full !== want.is_full)
                  report_mismatch("is_full", 32'(rsp_word.is_full), 32'(want.is_full));
            end
         end
      end
   end

   // Stimulus: directed table, then random phases, then drain and verdict.
   initial begin
      stim_row_type table_rows [19];
      rsp_word_type none;
      req_word_type w;
      int           n_sent;
      int           phase;
      int           enq_pct;
      int           len;

      none        = '0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      rsp_stall   = 1'b0;
      drive_typed = 1'b0;
      drive_rsp   = '0;
      fail_count  = 0;
      print_count = 0;
      quiet       = 1'b0;
      stall_left  = 0;
      pq_fill     = 0;

      // Dequeue from empty, extreme data and priorities, ties at both ends.
      table_rows[0]  = {make_req(CMD_DEQ, 32'h1234_5678, 8'h5A), 1'b1,
                        make_rsp(ST_EMPTY, 32'h0, 8'd0, 1'b1, 1'b0)};
      table_rows[1]  = {make_req(CMD_ENQ, 32'h7FFF_FFFF, 8'hFF), 1'b1,
                        make_rsp(ST_OK, 32'h0, 8'd1, 1'b0, 1'b0)};
      table_rows[2]  = {make_req(CMD_ENQ, 32'h8000_0000, 8'h00), 1'b1,
                        make_rsp(ST_OK, 32'h0, 8'd2, 1'b0, 1'b0)};
      table_rows[3]  = {make_req(CMD_ENQ, 32'hFFFF_FFFF, 8'hFF), 1'b0, none};
      table_rows[4]  = {make_req(CMD_ENQ, 32'h0000_0000, 8'h00), 1'b0, none};
      table_rows[5]  = {make_req(CMD_ENQ, 32'h5555_5555, 8'h80), 1'b0, none};
      table_rows[6]  = {make_req(CMD_ENQ, 32'hAAAA_AAAA, 8'h7F), 1'b0, none};
      table_rows[7]  = {make_req(CMD_ENQ, 32'h0000_0001, 8'hFF), 1'b0, none};
      table_rows[8]  = {make_req(CMD_DEQ, 32'hFFFF_FFFF, 8'hFF), 1'b0, none};
      table_rows[9]  = {make_req(CMD_DEQ, 32'h0000_0000, 8'h00), 1'b0, none};
      table_rows[10] = {make_req(CMD_DEQ, 32'hDEAD_BEEF, 8'h01), 1'b0, none};
      table_rows[11] = {make_req(CMD_DEQ, 32'h0000_0000, 8'h00), 1'b0, none};
      table_rows[12] = {make_req(CMD_DEQ, 32'h0000_0000, 8'h00), 1'b0, none};
      table_rows[13] = {make_req(CMD_DEQ, 32'h0000_0000, 8'h00), 1'b0, none};
      table_rows[14] = {make_req(CMD_DEQ, 32'h0000_0000, 8'h00), 1'b0, none};
      table_rows[15] = {make_req(CMD_DEQ, 32'h7FFF_FFFF, 8'h80), 1'b1,
                        make_rsp(ST_EMPTY, 32'h0, 8'd0, 1'b1, 1'b0)};
      table_rows[16] = {make_req(CMD_ENQ, 32'h0F0F_0F0F, 8'h01), 1'b1,
                        make_rsp(ST_OK, 32'h0, 8'd1, 1'b0, 1'b0)};
      table_rows[17] = {make_req(CMD_DEQ, 32'h0000_0000, 8'h00), 1'b1,
                        make_rsp(ST_OK, 32'h0F0F_0F0F, 8'd0, 1'b1, 1'b0)};
      table_rows[18] = {make_req(CMD_DEQ, 32'hFFFF_FFFF, 8'hFF), 1'b1,
                        make_rsp(ST_EMPTY, 32'h0, 8'd0, 1'b1, 1'b0)};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[i])
         send_word(table_rows[i].word, table_rows[i].typed, table_rows[i].rsp);

      // Fill past full first, then drain past empty, then mixed phases.
      n_sent = 0;
      phase  = 0;
      while (n_sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               enq_pct = 92;
               len     = 200;
            end
            1: begin
               enq_pct = 8;
               len     = 200;
            end
            default: begin
               case ($urandom_range(0, 2))
                  0:       enq_pct = 25;
                  1:       enq_pct = 50;
                  default: enq_pct = 80;
               endcase
               len = $urandom_range(60, 160);
            end
         endcase
         for (int k = 0; k < len && n_sent < RANDOM_ITEMS; k++) begin
            quiet          = (n_sent >= RANDOM_ITEMS - QUIET_ITEMS);
            w.cmd          = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            w.data_in      = $urandom;
            w.priority_req = pick_priority();
            send_word(w, 1'b0, none);
            n_sent++;
         end
         phase++;
      end
      req_valid <= 1'b0;

      // Wait for every outstanding response, then wait on for strays.
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
